>>> hw/rtl/url_percent_codec_defines.svh
// Assertion macros used by the codec back end (upc_back).
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/upc_pkg.sv
package upc_pkg;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam int         QUEUE_DEPTH  = 2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_HEX_LOWER = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef struct packed {
    logic       dir_wr;
    logic       direction;
    logic       hex_lower;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } entry_t;

  function automatic logic byte_acceptable(input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
         (b >= 8'h30 && b <= 8'h39) || b == 8'h2a || b == 8'h2b ||
         b == 8'h2d || b == 8'h2e || b == 8'h2f || b == 8'h40 || b == 8'h5f;
    return ok;
  endfunction

  function automatic logic [7:0] hex_digit_char(input logic [3:0] nib, input logic lower);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'b0, nib};
    end else begin
      c = (lower ? 8'h61 : 8'h41) + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] lenient_hex(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h30;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/upc_front.sv
module upc_front import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_data
);

  phase_t     ph_r, ph_nxt;
  logic [7:0] part_r, part_nxt;
  logic       accept;
  logic [7:0] hv, pv;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hv       = lenient_hex(in_byte);
  assign pv       = {hv[3:0], 4'b0};

  always_comb begin
    ph_nxt    = ph_r;
    part_nxt  = part_r;
    push_data = '0;
    push_data.last     = in_last;
    push_data.bytes[0] = in_byte;
    if (cfg.direction == DIR_ENCODE) begin
      if (byte_acceptable(in_byte)) begin
        push_data.cnt = 2'd1;
      end else begin
        push_data.cnt      = 2'd3;
        push_data.bytes[0] = PERCENT_CHAR;
        push_data.bytes[1] = hex_digit_char(in_byte[7:4], cfg.hex_lower);
        push_data.bytes[2] = hex_digit_char(in_byte[3:0], cfg.hex_lower);
      end
    end else begin
      case (ph_r)
        PH_PCT: begin
          if (in_last) begin
            ph_nxt             = PH_IDLE;
            push_data.cnt      = 2'd1;
            push_data.bytes[0] = pv;
          end else begin
            ph_nxt        = PH_DIGIT;
            part_nxt      = pv;
            push_data.cnt = 2'd0;
          end
        end
        PH_DIGIT: begin
          ph_nxt             = PH_IDLE;
          part_nxt           = '0;
          push_data.cnt      = 2'd1;
          push_data.bytes[0] = part_r + hv;
        end
        default: begin
          if (in_byte == PERCENT_CHAR && !in_last) begin
            ph_nxt        = PH_PCT;
            push_data.cnt = 2'd0;
          end else begin
            ph_nxt        = PH_IDLE;
            push_data.cnt = 2'd1;
          end
        end
      endcase
    end
  end

  assign push = accept && push_data.cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      part_r <= '0;
    end else if (cfg.dir_wr) begin
      ph_r   <= PH_IDLE;
      part_r <= '0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

>>> hw/rtl/upc_queue.sv
module upc_queue import upc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_data
);

  entry_t     mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full    = count_r == 2'(QUEUE_DEPTH);
  assign q_valid = count_r != 2'd0;
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/upc_back.sv
`include "url_percent_codec_defines.svh"

module upc_back import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  entry_t     q_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  entry_t     cur_r;
  logic [1:0] cnt_r;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;
  logic       out_free, emit;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = out_free && cnt_r != 2'd0;
  assign pop       = q_valid && (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_free));
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data;
    end else if (emit) begin
      cur_r.bytes <= {8'h00, cur_r.bytes[2:1]};
    end
    if (emit) begin
      out_byte_r <= cur_r.bytes[0];
      out_last_r <= cur_r.last && cnt_r == 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cnt_r <= q_data.cnt;
      end else if (emit) begin
        cnt_r <= cnt_r - 2'd1;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  `UPC_ASSERT_NEXT(a_three_after_pop, cnt_r != 2'd3 && !pop, cnt_r != 2'd3, "escape word count rose without a pop")
  `UPC_ASSERT_NEXT(a_last_only_final, emit && cnt_r > 2'd1, !out_last_r, "last flag on a non-final word")
  `UPC_ASSERT_NOW(a_no_idle_pop_loss, pop, q_valid, "pop from an empty queue")
  `UPC_ASSERT_NEXT(a_drain, out_free && cnt_r == 2'd0, !out_valid_r, "word shown with nothing pending")

endmodule

>>> hw/rtl/url_percent_codec.sv
// url_percent_codec: streaming percent encoder and decoder for URL path bytes.
// Input channel in_valid/in_stall carries one byte (in_byte) and an end mark
// (in_last) per word. Output channel out_valid/out_stall returns result words
// (out_byte, out_last); out_last is set on the final word an in_last byte causes.
// Encode (direction 0): acceptable bytes pass as one word; any other byte gives
// three words: '%' and two hex digits (case set by hex_lower).
// Decode (direction 1): "%XY" folds into one word; a trailing '%' or '%X' at
// in_last is flushed as one word. Bytes that only advance an escape give none.
// Each word goes from the queue through the word register to the output register.
// Throughput: one output word per cycle while out_stall is low, set by the
// single-word result port; an escaped encode byte gives three words.
// A two-entry queue sits between the classifier and the serializer, so input is
// still taken while the output register holds a stalled word; in_stall rises
// only when that queue is full. A stalled output word holds until taken.
// Reset (rst_n low, synchronous) clears both registers to 0 (encode, uppercase),
// the escape state, the queue and the output register. Writing direction also
// clears the escape state. Configure only while no words are in flight.
module url_percent_codec import upc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic   direction_r, hex_lower_r;
  logic   wr_en;
  cfg_t   cfg;
  logic   push, pop, q_full, q_valid;
  entry_t push_data, q_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      hex_lower_r <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DIRECTION: direction_r <= pwdata[0];
        REG_HEX_LOWER: hex_lower_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIRECTION: prdata = {31'b0, direction_r};
      REG_HEX_LOWER: prdata = {31'b0, hex_lower_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.dir_wr    = wr_en && paddr[2] == REG_DIRECTION;
  assign cfg.direction = direction_r;
  assign cfg.hex_lower = hex_lower_r;

  upc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  upc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  upc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
